>>> rtl/bfpa_pkg.sv
`default_nettype none
package bfpa_pkg;

    // partitions in the chain
    localparam int NUM_PARTS = 8;
    localparam int SIZE_W    = 16;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // request kinds
    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    localparam logic [SIZE_W-1:0] PART_SIZE_RESET [8] = '{
        16'd20, 16'd10, 16'd30, 16'd15, 16'd0, 16'd0, 16'd0, 16'd0
    };

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] part_index;
    } t_res;

    // word traveling down the chain
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [SIZE_W-1:0] req;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] diff;
    } t_tok;

    // end-of-scan marking of the chosen partition
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_commit;

    // size register write
    typedef struct packed {
        logic              we;
        logic [SIZE_W-1:0] data;
    } t_cfg_wr;

endpackage
`default_nettype wire

>>> rtl/best_fit_partition_allocator.sv
`default_nettype none
// a word accepted while not busy steps through the chain of partition cells, one cell per cycle,
//   and the result strobe is registered from the chain tail; o_busy holds off a new word until
//   the previous one has reached the chain tail
// reset: synchronous active low; all partitions free, sizes back to 20, 10, 30, 15, 0...
// the result strobe lasts one cycle and the receiver cannot stall it
module best_fit_partition_allocator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request side
    input  wire logic                               i_start,
    input  wire bfpa_pkg::t_req                     i_req,
    output logic                                    o_busy,
    // result side
    output logic                                    o_done,
    output bfpa_pkg::t_res                          o_res,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bfpa_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [bfpa_pkg::DATA_W-1:0]        pwdata,
    output logic [bfpa_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);

    // links between cells: link 0 feeds cell 0, link NUM_PARTS is the chain tail
    bfpa_pkg::t_tok              w_link [bfpa_pkg::NUM_PARTS+1];
    logic [bfpa_pkg::SIZE_W-1:0] w_size [bfpa_pkg::NUM_PARTS];
    bfpa_pkg::t_tok              w_head;
    bfpa_pkg::t_commit           w_commit;
    bfpa_pkg::t_tok              w_tail;
    logic                        w_accept;
    logic                        w_wr;
    logic [bfpa_pkg::IDX_W-1:0]  w_reg_idx;

    logic                        r_busy;
    logic                        r_done;
    bfpa_pkg::t_res              r_res;
    bfpa_pkg::t_res              n_res;

    assign w_accept  = i_start && !r_busy;
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    // byte address picks the register, one 32-bit slot each
    assign w_reg_idx = paddr[bfpa_pkg::ADDR_W-1:2];

    // a fresh word enters the chain with nothing chosen yet
    always_comb begin
        w_head.valid = w_accept;
        w_head.kind  = i_req.kind;
        w_head.req   = i_req.request_size;
        w_head.found = 1'b0;
        w_head.idx   = '0;
        w_head.diff  = '0;
    end

    assign w_link[0] = w_head;
    assign w_tail    = w_link[bfpa_pkg::NUM_PARTS];

    // best fit is only known at the tail, so the winner is marked there
    assign w_commit.valid = w_tail.valid && (w_tail.kind == bfpa_pkg::KIND_ALLOC)
                            && w_tail.found;
    assign w_commit.idx   = w_tail.idx;

    for (genvar g = 0; g < bfpa_pkg::NUM_PARTS; g++) begin : g_cell
        bfpa_pkg::t_cfg_wr w_cfg;

        assign w_cfg.we   = w_wr && (w_reg_idx == bfpa_pkg::IDX_W'(g));
        assign w_cfg.data = pwdata[bfpa_pkg::SIZE_W-1:0];

        bfpa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (bfpa_pkg::IDX_W'(g)),
            .i_cfg      (w_cfg),
            .i_commit   (w_commit),
            .i_tok      (w_link[g]),
            .o_tok      (w_link[g+1]),
            .o_size     (w_size[g])
        );
    end

    // register readback
    always_comb begin
        prdata = '0;
        if (32'(w_reg_idx) < bfpa_pkg::NUM_PARTS) begin
            prdata[bfpa_pkg::SIZE_W-1:0] = w_size[w_reg_idx];
        end
    end

    // status from what the word picked up along the chain
    always_comb begin
        if (w_tail.kind == bfpa_pkg::KIND_ALLOC) begin
            n_res.status = w_tail.found ? bfpa_pkg::ST_ALLOC : bfpa_pkg::ST_NOFIT;
        end else begin
            n_res.status = w_tail.found ? bfpa_pkg::ST_FREED : bfpa_pkg::ST_MISS;
        end
        n_res.part_index = w_tail.found ? w_tail.idx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // one word in the chain at a time
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            r_done <= w_tail.valid;
        end
        if (w_tail.valid) begin
            r_res <= n_res;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

>>> rtl/bfpa_cell.sv
`default_nettype none
module bfpa_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bfpa_pkg::IDX_W-1:0]      i_cell_idx,
    input  wire bfpa_pkg::t_cfg_wr               i_cfg,
    input  wire bfpa_pkg::t_commit               i_commit,
    input  wire bfpa_pkg::t_tok                  i_tok,
    output bfpa_pkg::t_tok                       o_tok,
    output logic [bfpa_pkg::SIZE_W-1:0]          o_size
);

    logic [bfpa_pkg::SIZE_W-1:0] r_size;
    logic                        r_in_use;
    bfpa_pkg::t_tok              r_tok;
    bfpa_pkg::t_tok              n_tok;
    logic                        n_in_use;
    logic [bfpa_pkg::SIZE_W-1:0] w_diff;
    logic                        w_fits;
    logic                        w_take;
    logic                        w_hit;

    always_comb begin
        w_diff = r_size - i_tok.req;
        w_fits = !r_in_use && (r_size != '0) && (r_size >= i_tok.req);
        w_take = i_tok.valid && (i_tok.kind == bfpa_pkg::KIND_ALLOC) && w_fits
                 && (!i_tok.found || (w_diff < i_tok.diff));
        // first allocated partition of matching size frees itself on the way
        w_hit  = i_tok.valid && (i_tok.kind == bfpa_pkg::KIND_RELEASE) && !i_tok.found
                 && r_in_use && (r_size == i_tok.req);

        n_tok = i_tok;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_cell_idx;
            n_tok.diff  = w_diff;
        end else if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_cell_idx;
        end

        n_in_use = r_in_use;
        if (i_commit.valid && (i_commit.idx == i_cell_idx)) begin
            n_in_use = 1'b1;
        end else if (w_hit) begin
            n_in_use = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= bfpa_pkg::PART_SIZE_RESET[i_cell_idx];
            r_in_use  <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                r_size <= i_cfg.data;
            end
            r_in_use    <= n_in_use;
            r_tok.valid <= n_tok.valid;
        end
        r_tok.kind  <= n_tok.kind;
        r_tok.req   <= n_tok.req;
        r_tok.found <= n_tok.found;
        r_tok.idx   <= n_tok.idx;
        r_tok.diff  <= n_tok.diff;
    end

    assign o_tok  = r_tok;
    assign o_size = r_size;

endmodule
`default_nettype wire
